// ===== rtl/core/cfdl_pkg.sv =====
// cfdl_pkg: shared types, constants and the microcode table of the
// model-free adaptive controller (register codes, datapath control words).
// No dependencies; imported by every module of the block.
`default_nettype none

package cfdl_pkg;

    // default widths, taken up by the top level parameters
    localparam int FRACTION_BITS_DEF = 16;
    localparam int WORD_BITS_DEF     = 32;

    // fixed port field widths
    localparam int FIELD_BITS   = 32;
    localparam int REG_BITS     = 31;
    localparam int CFG_IDX_BITS = 3;

    // multiplier digit width and program counter width
    localparam int DIGIT_BITS = 16;
    localparam int PC_BITS    = 5;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ETA      = 3'd0,
        CFG_MU       = 3'd1,
        CFG_RHO      = 3'd2,
        CFG_LAMBDA   = 3'd3,
        CFG_FALLBACK = 3'd4,
        CFG_EPS      = 3'd5
    } t_cfg_idx;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NOP,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_FALLBACK,
        OP_FINISH
    } t_op;

    // operand sources
    typedef enum logic [3:0] {
        SRC_PHI,
        SRC_PY,
        SRC_PU,
        SRC_PDU,
        SRC_T0,
        SRC_T1,
        SRC_T2,
        SRC_Y,
        SRC_YD,
        SRC_ETA,
        SRC_MU,
        SRC_RHO,
        SRC_LAMBDA
    } t_src;

    // result destinations
    typedef enum logic [2:0] {
        DST_NONE,
        DST_T0,
        DST_T1,
        DST_T2,
        DST_PHI,
        DST_PDU
    } t_dst;

    // sequencing conditions
    typedef enum logic [2:0] {
        CND_NEXT,
        CND_WAIT_IN,
        CND_PHI_OK,
        CND_WAIT_OUT,
        CND_GOTO
    } t_cnd;

    // one microcode control word
    typedef struct packed {
        t_op               op;
        t_src              sel_a;
        t_src              sel_b;
        t_dst              dst;
        t_cnd              cnd;
        logic [PC_BITS-1:0] target;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        t_op  op;
        t_src sel_a;
        t_src sel_b;
        t_dst dst;
        logic start;
        logic write;
        logic load_in;
        logic finish;
    } t_dp_ctl;

    // datapath to sequencer
    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic phi_ok;
        logic out_free;
    } t_dp_stat;

    // program labels
    localparam logic [PC_BITS-1:0] PC_IDLE = 5'd0;
    localparam logic [PC_BITS-1:0] PC_LAW  = 5'd12;

    function automatic t_uword mk(input t_op o, input t_src a, input t_src b, input t_dst d,
                                  input t_cnd c, input logic [PC_BITS-1:0] t);
        t_uword w;
        w.op     = o;
        w.sel_a  = a;
        w.sel_b  = b;
        w.dst    = d;
        w.cnd    = c;
        w.target = t;
        return w;
    endfunction

    // control program: phi estimator, reset test, control law, write-back
    function automatic t_uword ucode(input logic [PC_BITS-1:0] pc);
        t_uword w;
        unique case (pc)
            5'd0:  w = mk(OP_NOP,      SRC_T0,     SRC_T0,  DST_NONE, CND_WAIT_IN,  PC_IDLE);
            // dy = y - y(k-1)
            5'd1:  w = mk(OP_SUB,      SRC_Y,      SRC_PY,  DST_T0,   CND_NEXT,     PC_IDLE);
            5'd2:  w = mk(OP_MUL,      SRC_PHI,    SRC_PDU, DST_T1,   CND_NEXT,     PC_IDLE);
            5'd3:  w = mk(OP_SUB,      SRC_T0,     SRC_T1,  DST_T0,   CND_NEXT,     PC_IDLE);
            5'd4:  w = mk(OP_MUL,      SRC_ETA,    SRC_T0,  DST_T0,   CND_NEXT,     PC_IDLE);
            5'd5:  w = mk(OP_MUL,      SRC_T0,     SRC_PDU, DST_T0,   CND_NEXT,     PC_IDLE);
            5'd6:  w = mk(OP_MUL,      SRC_PDU,    SRC_PDU, DST_T1,   CND_NEXT,     PC_IDLE);
            5'd7:  w = mk(OP_ADD,      SRC_MU,     SRC_T1,  DST_T1,   CND_NEXT,     PC_IDLE);
            5'd8:  w = mk(OP_DIV,      SRC_T0,     SRC_T1,  DST_T0,   CND_NEXT,     PC_IDLE);
            5'd9:  w = mk(OP_ADD,      SRC_PHI,    SRC_T0,  DST_PHI,  CND_NEXT,     PC_IDLE);
            // keep phi unless it or the last drive step is too small
            5'd10: w = mk(OP_NOP,      SRC_T0,     SRC_T0,  DST_NONE, CND_PHI_OK,   PC_LAW);
            5'd11: w = mk(OP_FALLBACK, SRC_T0,     SRC_T0,  DST_PHI,  CND_NEXT,     PC_IDLE);
            // control law
            5'd12: w = mk(OP_SUB,      SRC_YD,     SRC_Y,   DST_T2,   CND_NEXT,     PC_IDLE);
            5'd13: w = mk(OP_MUL,      SRC_RHO,    SRC_PHI, DST_T0,   CND_NEXT,     PC_IDLE);
            5'd14: w = mk(OP_MUL,      SRC_T0,     SRC_T2,  DST_T0,   CND_NEXT,     PC_IDLE);
            5'd15: w = mk(OP_MUL,      SRC_PHI,    SRC_PHI, DST_T1,   CND_NEXT,     PC_IDLE);
            5'd16: w = mk(OP_ADD,      SRC_LAMBDA, SRC_T1,  DST_T1,   CND_NEXT,     PC_IDLE);
            5'd17: w = mk(OP_DIV,      SRC_T0,     SRC_T1,  DST_T0,   CND_NEXT,     PC_IDLE);
            5'd18: w = mk(OP_ADD,      SRC_PU,     SRC_T0,  DST_T0,   CND_NEXT,     PC_IDLE);
            5'd19: w = mk(OP_SUB,      SRC_T0,     SRC_PU,  DST_PDU,  CND_NEXT,     PC_IDLE);
            5'd20: w = mk(OP_FINISH,   SRC_T0,     SRC_T0,  DST_NONE, CND_WAIT_OUT, PC_IDLE);
            default: w = mk(OP_NOP,    SRC_T0,     SRC_T0,  DST_NONE, CND_GOTO,     PC_IDLE);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cfdl_mul.sv =====
// cfdl_mul: digit-serial signed fixed-point multiplier with saturation,
// one 16-bit digit of the second operand per cycle. Depends on cfdl_pkg.
`default_nettype none

module cfdl_mul
    import cfdl_pkg::*;
#(
    parameter int  WORD_BITS     = WORD_BITS_DEF,
    parameter int  FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int OW            = (WORD_BITS > FIELD_BITS) ? WORD_BITS : FIELD_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [OW-1:0] i_a,
    input  wire logic signed [OW-1:0] i_b,
    output logic                      o_done,
    output logic signed [OW-1:0]      o_res
);

    localparam int ND = (OW + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int BW = ND * DIGIT_BITS;
    localparam int AW = OW + BW;
    localparam int PW = OW + DIGIT_BITS;
    localparam int CW = $clog2(ND) + 1;
    localparam logic [AW-1:0] LIM     = AW'({(WORD_BITS-1){1'b1}});
    localparam logic [AW-1:0] LIM_NEG = LIM + AW'(1);
    localparam logic [OW-1:0] MAX_O   = OW'({(WORD_BITS-1){1'b1}});
    localparam logic [OW-1:0] MIN_O   = ~MAX_O;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [OW-1:0] r_ma;
    logic [BW-1:0] r_mb;
    logic [AW-1:0] r_acc;
    logic          r_neg;

    logic [OW-1:0] a_mag;
    logic [OW-1:0] b_mag;
    logic [PW-1:0] prod;
    logic [AW-1:0] acc_next;
    logic [AW-1:0] shifted;

    // operand magnitudes
    assign a_mag = i_a[OW-1] ? (~i_a + OW'(1)) : i_a;
    assign b_mag = i_b[OW-1] ? (~i_b + OW'(1)) : i_b;

    // one partial product per cycle, most significant digit first
    assign prod     = PW'(r_ma) * PW'(r_mb[BW-1 -: DIGIT_BITS]);
    assign acc_next = (r_acc << DIGIT_BITS) + AW'(prod);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CW'(ND - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(ND - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // operands and accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= a_mag;
            r_mb  <= BW'(b_mag);
            r_acc <= '0;
            r_neg <= i_a[OW-1] ^ i_b[OW-1];
        end else if (r_busy) begin
            r_acc <= acc_next;
            r_mb  <= r_mb << DIGIT_BITS;
        end
    end

    // scale and saturate
    assign shifted = r_acc >> FRACTION_BITS;

    always_comb begin
        if (r_neg) begin
            o_res = (shifted > LIM_NEG) ? MIN_O : (~shifted[OW-1:0] + OW'(1));
        end else begin
            o_res = (shifted > LIM) ? MAX_O : shifted[OW-1:0];
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== rtl/core/cfdl_div.sv =====
// cfdl_div: restoring radix-2 signed fixed-point divider, quotient scaled by
// the fraction bits, saturated, zero for a zero divisor. Depends on cfdl_pkg.
`default_nettype none

module cfdl_div
    import cfdl_pkg::*;
#(
    parameter int  WORD_BITS     = WORD_BITS_DEF,
    parameter int  FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int OW            = (WORD_BITS > FIELD_BITS) ? WORD_BITS : FIELD_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [OW-1:0] i_num,
    input  wire logic signed [OW-1:0] i_den,
    output logic                      o_done,
    output logic signed [OW-1:0]      o_res
);

    localparam int NW = OW + FRACTION_BITS;
    localparam int CW = $clog2(NW + 1);
    localparam logic [NW-1:0] LIM     = NW'({(WORD_BITS-1){1'b1}});
    localparam logic [NW-1:0] LIM_NEG = LIM + NW'(1);
    localparam logic [OW-1:0] MAX_O   = OW'({(WORD_BITS-1){1'b1}});
    localparam logic [OW-1:0] MIN_O   = ~MAX_O;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_sh;
    logic [OW-1:0] r_rem;
    logic [OW-1:0] r_d;
    logic          r_neg;
    logic          r_zero;

    logic [OW-1:0] n_mag;
    logic [OW-1:0] d_mag;
    logic [OW:0]   trial;
    logic          ge;
    logic [OW-1:0] rem_next;

    assign n_mag = i_num[OW-1] ? (~i_num + OW'(1)) : i_num;
    assign d_mag = i_den[OW-1] ? (~i_den + OW'(1)) : i_den;

    // one quotient bit per cycle
    assign trial    = {r_rem, r_sh[NW-1]};
    assign ge       = trial >= {1'b0, r_d};
    assign rem_next = ge ? OW'(trial - {1'b0, r_d}) : trial[OW-1:0];

    // control, a zero divisor finishes right away
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= i_start ? (d_mag == '0) : (r_busy && (r_cnt == CW'(NW - 1)));
            if (i_start) begin
                r_cnt  <= '0;
                r_busy <= (d_mag != '0);
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // numerator shifts out at the top, quotient shifts in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh   <= NW'(n_mag) << FRACTION_BITS;
            r_rem  <= '0;
            r_d    <= d_mag;
            r_neg  <= i_num[OW-1] ^ i_den[OW-1];
            r_zero <= (d_mag == '0);
        end else if (r_busy) begin
            r_sh  <= {r_sh[NW-2:0], ge};
            r_rem <= rem_next;
        end
    end

    // saturate the quotient
    always_comb begin
        if (r_zero) begin
            o_res = '0;
        end else if (r_neg) begin
            o_res = (r_sh > LIM_NEG) ? MIN_O : (~r_sh[OW-1:0] + OW'(1));
        end else begin
            o_res = (r_sh > LIM) ? MAX_O : r_sh[OW-1:0];
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== rtl/core/cfdl_datapath.sv =====
// cfdl_datapath: register file, saturating adder, configuration registers,
// output word register and the shared multiplier and divider.
// Depends on cfdl_pkg, cfdl_mul and cfdl_div.
`default_nettype none

module cfdl_datapath
    import cfdl_pkg::*;
#(
    parameter int  WORD_BITS     = WORD_BITS_DEF,
    parameter int  FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int OW            = (WORD_BITS > FIELD_BITS) ? WORD_BITS : FIELD_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_dp_ctl                       i_ctl,
    output t_dp_stat                           o_stat,
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  wire logic [REG_BITS-1:0]           i_cfg_data,
    input  wire logic signed [FIELD_BITS-1:0]  i_measured_output,
    input  wire logic signed [FIELD_BITS-1:0]  i_target_next,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [FIELD_BITS-1:0]       o_drive,
    output logic signed [FIELD_BITS-1:0]       o_phi_estimate,
    output logic                               o_phi_was_reset
);

    localparam logic signed [OW:0] MAX_W = {1'b0, OW'({(WORD_BITS-1){1'b1}})};
    localparam logic signed [OW:0] MIN_W = ~MAX_W;
    localparam logic signed [OW:0] PHI_RAW = (OW+1)'(2) << FRACTION_BITS;
    localparam logic signed [OW-1:0] PHI_INIT = (PHI_RAW > MAX_W) ? MAX_W[OW-1:0]
                                                                  : PHI_RAW[OW-1:0];
    localparam int unsigned ONE_Q = 1 << FRACTION_BITS;
    localparam logic [REG_BITS-1:0] RST_ETA    = REG_BITS'(ONE_Q);
    localparam logic [REG_BITS-1:0] RST_MU     = REG_BITS'(ONE_Q);
    localparam logic [REG_BITS-1:0] RST_RHO    = REG_BITS'((6 * ONE_Q + 5) / 10);
    localparam logic [REG_BITS-1:0] RST_LAMBDA = REG_BITS'((ONE_Q + 5) / 10);
    localparam logic [REG_BITS-1:0] RST_FB     = REG_BITS'(ONE_Q / 2);
    localparam logic [REG_BITS-1:0] RST_EPS    = REG_BITS'(1);

    // configuration
    logic [REG_BITS-1:0] r_eta, r_mu, r_rho, r_lambda, r_fb, r_eps;

    // controller state and scratch
    logic signed [OW-1:0] r_phi, r_py, r_pu, r_pdu;
    logic signed [OW-1:0] r_t0, r_t1, r_t2;
    logic signed [FIELD_BITS-1:0] r_y, r_yd;
    logic r_flag;

    // output word
    logic                         r_out_valid;
    logic signed [FIELD_BITS-1:0] r_out_drive;
    logic signed [FIELD_BITS-1:0] r_out_phi;
    logic                         r_out_flag;

    logic signed [OW-1:0] y_ext, yd_ext;
    logic signed [OW-1:0] op_a, op_b, res;
    logic signed [OW:0]   sum_v, dif_v, fb_v;
    logic signed [OW-1:0] mul_res, div_res;
    logic                 mul_done, div_done;
    logic [OW-1:0]        pdu_mag;

    function automatic logic signed [OW-1:0] sat_w(input logic signed [OW:0] v);
        if (v > MAX_W) begin
            return MAX_W[OW-1:0];
        end else if (v < MIN_W) begin
            return MIN_W[OW-1:0];
        end
        return v[OW-1:0];
    endfunction

    function automatic logic signed [OW-1:0] pick(input t_src s,
                                                  input logic signed [OW-1:0] phi,
                                                  input logic signed [OW-1:0] py,
                                                  input logic signed [OW-1:0] pu,
                                                  input logic signed [OW-1:0] pdu,
                                                  input logic signed [OW-1:0] t0,
                                                  input logic signed [OW-1:0] t1,
                                                  input logic signed [OW-1:0] t2,
                                                  input logic signed [OW-1:0] y,
                                                  input logic signed [OW-1:0] yd);
        logic signed [OW-1:0] v;
        unique case (s)
            SRC_PHI:    v = phi;
            SRC_PY:     v = py;
            SRC_PU:     v = pu;
            SRC_PDU:    v = pdu;
            SRC_T0:     v = t0;
            SRC_T1:     v = t1;
            SRC_T2:     v = t2;
            SRC_Y:      v = y;
            SRC_YD:     v = yd;
            SRC_ETA:    v = $signed(OW'(r_eta));
            SRC_MU:     v = $signed(OW'(r_mu));
            SRC_RHO:    v = $signed(OW'(r_rho));
            SRC_LAMBDA: v = $signed(OW'(r_lambda));
            default:    v = t0;
        endcase
        return v;
    endfunction

    assign y_ext  = OW'(r_y);
    assign yd_ext = OW'(r_yd);

    // operand selection
    always_comb begin
        op_a = pick(i_ctl.sel_a, r_phi, r_py, r_pu, r_pdu, r_t0, r_t1, r_t2, y_ext, yd_ext);
        op_b = pick(i_ctl.sel_b, r_phi, r_py, r_pu, r_pdu, r_t0, r_t1, r_t2, y_ext, yd_ext);
    end

    // saturating add and subtract
    assign sum_v = (OW+1)'(op_a) + (OW+1)'(op_b);
    assign dif_v = (OW+1)'(op_a) - (OW+1)'(op_b);
    assign fb_v  = $signed((OW+1)'(r_fb));

    // shared multi-cycle units
    cfdl_mul #(
        .WORD_BITS     (WORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.start && (i_ctl.op == OP_MUL)),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    cfdl_div #(
        .WORD_BITS     (WORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.start && (i_ctl.op == OP_DIV)),
        .i_num   (op_a),
        .i_den   (op_b),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    // result selection
    always_comb begin
        unique case (i_ctl.op)
            OP_ADD:      res = sat_w(sum_v);
            OP_SUB:      res = sat_w(dif_v);
            OP_MUL:      res = mul_res;
            OP_DIV:      res = div_res;
            OP_FALLBACK: res = sat_w(fb_v);
            default:     res = r_t0;
        endcase
    end

    // phi reset test on the updated phi and the last drive step
    assign pdu_mag = r_pdu[OW-1] ? (~r_pdu + OW'(1)) : r_pdu;

    always_comb begin
        o_stat.mul_done = mul_done;
        o_stat.div_done = div_done;
        o_stat.phi_ok   = !((r_phi < $signed(OW'(r_eps))) || (pdu_mag < OW'(r_eps)));
        o_stat.out_free = !r_out_valid || i_ready;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta    <= RST_ETA;
            r_mu     <= RST_MU;
            r_rho    <= RST_RHO;
            r_lambda <= RST_LAMBDA;
            r_fb     <= RST_FB;
            r_eps    <= RST_EPS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ETA:      r_eta    <= i_cfg_data;
                CFG_MU:       r_mu     <= i_cfg_data;
                CFG_RHO:      r_rho    <= i_cfg_data;
                CFG_LAMBDA:   r_lambda <= i_cfg_data;
                CFG_FALLBACK: r_fb     <= i_cfg_data;
                CFG_EPS:      r_eps    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // controller state kept across samples
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phi  <= PHI_INIT;
            r_py   <= '0;
            r_pu   <= '0;
            r_pdu  <= '0;
            r_flag <= 1'b0;
        end else begin
            if (i_ctl.load_in) begin
                r_flag <= 1'b0;
            end
            if (i_ctl.write && (i_ctl.op == OP_FALLBACK)) begin
                r_flag <= 1'b1;
            end
            if (i_ctl.write && (i_ctl.dst == DST_PHI)) begin
                r_phi <= res;
            end
            if (i_ctl.write && (i_ctl.dst == DST_PDU)) begin
                r_pdu <= res;
            end
            if (i_ctl.finish) begin
                r_pu <= r_t0;
                r_py <= y_ext;
            end
        end
    end

    // scratch registers and captured input word
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_y  <= i_measured_output;
            r_yd <= i_target_next;
        end
        if (i_ctl.write) begin
            unique case (i_ctl.dst)
                DST_T0: r_t0 <= res;
                DST_T1: r_t1 <= res;
                DST_T2: r_t2 <= res;
                default: begin
                end
            endcase
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_out_drive <= r_t0[FIELD_BITS-1:0];
            r_out_phi   <= r_phi[FIELD_BITS-1:0];
            r_out_flag  <= r_flag;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_drive         = r_out_drive;
    assign o_phi_estimate  = r_out_phi;
    assign o_phi_was_reset = r_out_flag;

endmodule

`default_nettype wire

// ===== rtl/core/cfdl_model_free_adaptive_controller_unit.sv =====
// Model-free adaptive controller (compact form, nu = 1), microcoded sequencer.
// Handles one sample at a time: the next input word is accepted only after the result
// of the last one has been written to the output register; the bit-serial divider,
// run twice per sample, takes most of the time per sample.
// Synchronous active-low reset: phi = 2.0, stored output/drive/step zero,
// registers to eta 1.0, mu 1.0, rho 0.6, lambda 0.1, fallback 0.5, epsilon 1 LSB.
`default_nettype none

module cfdl_model_free_adaptive_controller_unit
    import cfdl_pkg::*;
#(
    parameter int WORD_BITS     = WORD_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // input stream
    input  wire logic                    i_s_tvalid,
    output logic                         o_s_tready,
    input  wire logic [2*FIELD_BITS-1:0] i_s_tdata,   // measured_output, target_next
    // output stream
    output logic                         o_m_tvalid,
    input  wire logic                    i_m_tready,
    output logic [2*FIELD_BITS-1:0]      o_m_tdata,   // drive, phi_estimate
    output logic                         o_m_tuser,   // phi_was_reset
    // configuration writes
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [REG_BITS-1:0]     i_cfg_data
);

    logic [PC_BITS-1:0] r_pc, n_pc;
    logic               r_run, n_run;

    t_uword   uw;
    t_dp_ctl  ctl;
    t_dp_stat stat;
    logic     is_unit;
    logic     unit_done;
    logic     step_done;

    logic signed [FIELD_BITS-1:0] drive;
    logic signed [FIELD_BITS-1:0] phi_est;

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= PC_IDLE;
            r_run <= 1'b0;
        end else begin
            r_pc  <= n_pc;
            r_run <= n_run;
        end
    end

    // control word decode, step completion and next step
    always_comb begin
        uw        = ucode(r_pc);
        is_unit   = (uw.op == OP_MUL) || (uw.op == OP_DIV);
        unit_done = (uw.op == OP_MUL) ? stat.mul_done : stat.div_done;

        unique case (uw.cnd)
            CND_WAIT_IN:  step_done = i_s_tvalid;
            CND_WAIT_OUT: step_done = stat.out_free;
            default:      step_done = is_unit ? unit_done : 1'b1;
        endcase

        ctl.op      = uw.op;
        ctl.sel_a   = uw.sel_a;
        ctl.sel_b   = uw.sel_b;
        ctl.dst     = uw.dst;
        ctl.start   = is_unit && !r_run;
        ctl.write   = is_unit ? unit_done
                              : ((uw.op == OP_ADD) || (uw.op == OP_SUB)
                                 || (uw.op == OP_FALLBACK));
        ctl.load_in = (uw.cnd == CND_WAIT_IN) && i_s_tvalid;
        ctl.finish  = (uw.op == OP_FINISH) && stat.out_free;

        n_run = r_run;
        if (ctl.start) begin
            n_run = 1'b1;
        end
        if (is_unit && unit_done) begin
            n_run = 1'b0;
        end

        n_pc = r_pc;
        if (step_done) begin
            priority if ((uw.cnd == CND_GOTO) || (uw.cnd == CND_WAIT_OUT)) begin
                n_pc = uw.target;
            end else if ((uw.cnd == CND_PHI_OK) && stat.phi_ok) begin
                n_pc = uw.target;
            end else begin
                n_pc = r_pc + PC_BITS'(1);
            end
        end
    end

    assign o_s_tready = (uw.cnd == CND_WAIT_IN);

    cfdl_datapath #(
        .WORD_BITS     (WORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .o_stat            (stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_measured_output (i_s_tdata[FIELD_BITS-1:0]),
        .i_target_next     (i_s_tdata[2*FIELD_BITS-1:FIELD_BITS]),
        .o_valid           (o_m_tvalid),
        .i_ready           (i_m_tready),
        .o_drive           (drive),
        .o_phi_estimate    (phi_est),
        .o_phi_was_reset   (o_m_tuser)
    );

    assign o_m_tdata = {phi_est, drive};

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// tb: self-checking bench for the model-free adaptive controller unit.
// Drives sample words, predicts drive/phi with a Q16.16 controller model, checks results.
// Depends on cfdl_pkg and cfdl_model_free_adaptive_controller_unit.
`default_nettype none

module tb;
    import cfdl_pkg::*;

    localparam int FRAC = FRACTION_BITS_DEF;
    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -WORD_MAX - 1;
    localparam logic [127:0] MAG_POS_MAX = 128'd2147483647;
    localparam logic [127:0] MAG_NEG_MAX = 128'd2147483648;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED_HI = 3'd7;
    localparam logic [REG_BITS-1:0] REG_ALL_ONES = 31'h7FFF_FFFF;
    localparam int PHASES = 8;
    localparam int PHASE_SAMPLES = 160;
    localparam int STALL_LIMIT = 8000;
    localparam int HOLDOFF_AT = 150;
    localparam int HOLDOFF_CYCLES = 1500;
    localparam int TAIL_CYCLES = 200;

    // one input word: measured_output in the low half
    typedef struct packed {
        logic [FIELD_BITS-1:0] target;
        logic [FIELD_BITS-1:0] measured;
    } t_sample;

    // one result: same layout as {tuser, tdata}
    typedef struct packed {
        logic                  reset_hit;
        logic [FIELD_BITS-1:0] phi;
        logic [FIELD_BITS-1:0] drive;
    } t_ctl_result;

    logic clk;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    t_sample s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [2*FIELD_BITS-1:0] m_tdata;
    logic m_tuser;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
    logic [REG_BITS-1:0] cfg_data = '0;

    int unsigned send_idle_pct = 14;
    int unsigned recv_idle_pct = 61;

    t_sample samples_q[$];
    t_ctl_result replies_due[$];
    int mismatches = 0;
    int replies_seen = 0;
    int holdoff_left = 0;
    int quiet_cycles = 0;

    // controller copy: gains and state at their reset values
    longint eta_q = 65536, mu_q = 65536, rho_q = 39322, lambda_q = 6554;
    longint fallback_q = 32768, eps_q = 1;
    longint phi_cur = 131072, y_prev = 0, u_prev = 0, du_prev = 0;

    // random walk for plant-like samples
    longint walk_y = 0, walk_target = 0;

    cfdl_model_free_adaptive_controller_unit uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),    // measured_output, target_next
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),    // drive, phi_estimate
        .o_m_tuser  (m_tuser),    // phi_was_reset
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // fixed point helpers; clamp_word, pack_word, fx_mul and fx_div saturate to the 32-bit word
    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX) return WORD_MAX;
        if (v < WORD_MIN) return WORD_MIN;
        return v;
    endfunction

    function automatic logic [63:0] magnitude(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint pack_word(input logic neg, input logic [127:0] q);
        if (neg) return (q > MAG_NEG_MAX) ? WORD_MIN : -longint'(q[63:0]);
        return (q > MAG_POS_MAX) ? WORD_MAX : longint'(q[63:0]);
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        logic [127:0] p;
        p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        return pack_word((a < 0) != (b < 0), p >> FRAC);
    endfunction

    function automatic longint fx_div(input longint num, input longint den);
        logic [127:0] n;
        logic [127:0] d;
        if (den == 0) return 0;
        n = {64'd0, magnitude(num)} << FRAC;
        d = {64'd0, magnitude(den)};
        return pack_word((num < 0) != (den < 0), n / d);
    endfunction

    // one controller sample: phi update, fallback test, control law, state update
    function automatic t_ctl_result advance_controller(input t_sample s);
        longint y, yd, du, dy, err, num, den, phi, u, e;
        t_ctl_result r;
        y = longint'($signed(s.measured));
        yd = longint'($signed(s.target));
        du = du_prev;
        dy = clamp_word(y - y_prev);
        err = clamp_word(dy - fx_mul(phi_cur, du));
        num = fx_mul(fx_mul(eta_q, err), du);
        den = clamp_word(mu_q + fx_mul(du, du));
        phi = clamp_word(phi_cur + fx_div(num, den));
        r.reset_hit = 1'b0;
        if (phi < eps_q || magnitude(du) < 64'(eps_q)) begin
            phi = clamp_word(fallback_q);
            r.reset_hit = 1'b1;
        end
        e = clamp_word(yd - y);
        num = fx_mul(fx_mul(rho_q, phi), e);
        den = clamp_word(lambda_q + fx_mul(phi, phi));
        u = clamp_word(u_prev + fx_div(num, den));
        phi_cur = phi;
        du_prev = clamp_word(u - u_prev);
        u_prev = u;
        y_prev = y;
        r.drive = u[31:0];
        r.phi = phi[31:0];
        return r;
    endfunction

    // register write, mirrored into the controller copy
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [REG_BITS-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        case (idx)
            CFG_ETA:      eta_q = val;
            CFG_MU:       mu_q = val;
            CFG_RHO:      rho_q = val;
            CFG_LAMBDA:   lambda_q = val;
            CFG_FALLBACK: fallback_q = val;
            CFG_EPS:      eps_q = val;
            default: ;
        endcase
    endtask

    // gain per phase: all ones, lowest legal, full random or a moderate range
    function automatic logic [REG_BITS-1:0] pick_gain(input int phase, input int unsigned lo,
                                                      input int unsigned hi);
        logic [REG_BITS-1:0] v;
        case (phase)
            1: v = REG_ALL_ONES;
            2: v = REG_BITS'(lo);
            5: begin
                v = REG_BITS'($urandom);
                if (v < lo) v = REG_BITS'(lo);
            end
            default: v = REG_BITS'($urandom_range(hi, lo));
        endcase
        return v;
    endfunction

    function automatic logic [FIELD_BITS-1:0] corner_value();
        case ($urandom_range(4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    function automatic void push_sample(input logic [FIELD_BITS-1:0] y,
                                        input logic [FIELD_BITS-1:0] yd);
        samples_q.insert(samples_q.size(), t_sample'{target: yd, measured: y});
    endfunction

    // mostly a slowly moving plant output against a stepped target, some noise and corners
    task automatic queue_samples(input int count);
        int unsigned pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                walk_y += longint'($urandom_range(8192)) - 4096;
                if ($urandom_range(19) == 0)
                    walk_y += longint'($urandom_range(40 << 16)) - (20 << 16);
                if (walk_y > (200 << 16) || walk_y < -(200 << 16)) walk_y = 0;
                if ($urandom_range(19) == 0)
                    walk_target = longint'($urandom_range(200 << 16)) - (100 << 16);
                push_sample(walk_y[31:0], walk_target[31:0]);
            end else if (pick < 85) begin
                push_sample($urandom, $urandom);
            end else begin
                push_sample(corner_value(), corner_value());
            end
        end
    endtask

    // wait until every word is sent and every result has come back
    task automatic drain();
        while (samples_q.size() != 0 || s_tvalid || replies_due.size() != 0)
            @(negedge clk);
    endtask

    // sample sender
    always @(posedge clk) begin : send_words
        logic offer;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                replies_due.insert(replies_due.size(), advance_controller(s_tdata));
                void'(samples_q.pop_front());
                offer = 1'b0;
            end
            if (!offer && samples_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tdata <= samples_q[0];
                offer = 1'b1;
            end
            s_tvalid <= offer;
        end
    end

    // result checker and receiver stalls
    always @(posedge clk) begin : check_words
        t_ctl_result want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                replies_seen++;
                if (replies_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: drive %h phi %h reset %b",
                                 m_tdata[31:0], m_tdata[63:32], m_tuser);
                end else begin
                    want = replies_due.pop_front();
                    if (m_tdata[31:0] !== want.drive || m_tdata[63:32] !== want.phi
                        || m_tuser !== want.reset_hit) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: exp drive %h phi %h reset %b, got %h %h %b",
                                     replies_seen, want.drive, want.phi, want.reset_hit,
                                     m_tdata[31:0], m_tdata[63:32], m_tuser);
                    end
                end
                // one long hold-off so the block backs up into its input
                if (replies_seen == HOLDOFF_AT) holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left != 0) begin
                holdoff_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // reset, register phases and sample stimulus
    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // writes to unmapped indexes must leave the gains alone
        write_reg(CFG_UNMAPPED_LO, REG_BITS'($urandom));
        write_reg(CFG_UNMAPPED_HI, REG_BITS'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);

        // directed: zero drive step, small steps, field extremes
        push_sample(32'h0000_0000, 32'h0000_0000);
        push_sample(32'h0000_0000, 32'h0001_0000);
        push_sample(32'h0001_0000, 32'h0001_0000);
        push_sample(32'h0001_8000, 32'h0003_0000);
        push_sample(32'h0002_0000, 32'h0002_8000);
        push_sample(32'h0002_1999, 32'h0002_8000);
        push_sample(32'h0002_4CCC, 32'h0002_8000);
        push_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_sample(32'h8000_0000, 32'h8000_0000);
        push_sample(32'h7FFF_FFFF, 32'h8000_0000);
        push_sample(32'h8000_0000, 32'h7FFF_FFFF);
        push_sample(32'h0000_0000, 32'h0000_0000);
        push_sample(32'hFFFF_FFFF, 32'h0000_0001);
        push_sample(32'h0000_0001, 32'hFFFF_FFFF);
        push_sample(32'h8000_0001, 32'h7FFF_FFFE);
        push_sample(32'hFFFF_0000, 32'h0001_0000);
        push_sample(32'h0005_0000, 32'hFFFB_0000);
        push_sample(32'h0000_0000, 32'h0000_0000);

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                drain();
                @(posedge clk);
                // receiver-heavy stalls, then sender-heavy, then none
                send_idle_pct <= (p < 3) ? 14 : (p < 6) ? 61 : 0;
                recv_idle_pct <= (p < 3) ? 61 : (p < 6) ? 14 : 0;
                write_reg(CFG_ETA,      pick_gain(p, 0, 4 << 16));
                write_reg(CFG_MU,       pick_gain(p, 1, 4 << 16));
                write_reg(CFG_RHO,      pick_gain(p, 0, 2 << 16));
                write_reg(CFG_LAMBDA,   pick_gain(p, 1, 1 << 16));
                write_reg(CFG_FALLBACK, pick_gain(p, 0, 4 << 16));
                write_reg(CFG_EPS,      pick_gain(p, 0, 1024));
                @(posedge clk);
                cfg_we <= 1'b0;
                @(negedge clk);
            end
            queue_samples(PHASE_SAMPLES);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && replies_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
